// ----- hdl/calendar_date_calculator_top_macros.svh -----
// Assertion macros for the calendar date calculator checker.
// Expects signals clk and rst_n in the scope of use.
`ifndef CALENDAR_DATE_CALCULATOR_TOP_MACROS_SVH
`define CALENDAR_DATE_CALCULATOR_TOP_MACROS_SVH

// same-cycle implication
`define CDCALC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CDCALC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/cdcalc_pkg.sv -----
// Package for the calendar date calculator: widths, reciprocal constants,
// calendar tables and shared types. No dependencies.
`timescale 1ns / 1ps

package cdcalc_pkg;

  localparam int CODE_W = 27;
  localparam int YEAR_W = 14;
  localparam int MD_W   = 7;
  localparam int DOY_W  = 9;
  localparam int DNUM_W = 18;

  // pipeline registers from input beat to result beat
  localparam int PIPE_DEPTH = 6;

  // n / 10000 = ((n >> 4) * RECIP_10000) >> 32, exact for 27-bit n
  localparam logic [22:0] RECIP_10000 = 23'd6871948;
  localparam logic [13:0] TEN_THOUSAND = 14'd10000;
  // n / 100 = ((n >> 2) * RECIP_100) >> 16, exact for 14-bit n
  localparam logic [11:0] RECIP_100 = 12'd2622;
  localparam logic [6:0]  HUNDRED   = 7'd100;

  localparam logic [YEAR_W-1:0] YEAR_FIRST = 14'd1703;
  localparam logic [YEAR_W-1:0] YEAR_LAST  = 14'd2100;
  // leap years in 1..1702
  localparam logic [11:0] LEAPS_BEFORE_EPOCH = 12'd412;
  localparam logic [8:0]  DAYS_COMMON = 9'd365;
  localparam logic [8:0]  DAYS_LEAP   = 9'd366;

  typedef struct packed {
    logic              ok;
    logic [YEAR_W-1:0] year;
    logic [MD_W-1:0]   month;
    logic [MD_W-1:0]   day;
    logic [2:0]        quarter;
    logic              leap;
    logic [DOY_W-1:0]  doy;
    logic [DOY_W-1:0]  left;
    logic [DNUM_W-1:0] dnum;
  } date_info_t;

  typedef struct packed {
    logic adv;
    logic out_vld;
  } pipe_ctl_t;

  // days before month, month index 0..11
  function automatic logic [8:0] cum_days(input logic [3:0] mi);
    case (mi)
      4'd0:    return 9'd0;
      4'd1:    return 9'd31;
      4'd2:    return 9'd59;
      4'd3:    return 9'd90;
      4'd4:    return 9'd120;
      4'd5:    return 9'd151;
      4'd6:    return 9'd181;
      4'd7:    return 9'd212;
      4'd8:    return 9'd243;
      4'd9:    return 9'd273;
      4'd10:   return 9'd304;
      4'd11:   return 9'd334;
      default: return 9'd0;
    endcase
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] mi, input logic leap);
    case (mi)
      4'd1:                        return leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:     return 5'd30;
      4'd0, 4'd2, 4'd4, 4'd6,
      4'd7, 4'd9, 4'd11:           return 5'd31;
      default:                     return 5'd0;
    endcase
  endfunction

  function automatic logic [2:0] quarter_of(input logic [3:0] mi);
    case (mi)
      4'd0, 4'd1, 4'd2:   return 3'd1;
      4'd3, 4'd4, 4'd5:   return 3'd2;
      4'd6, 4'd7, 4'd8:   return 3'd3;
      4'd9, 4'd10, 4'd11: return 3'd4;
      default:            return 3'd0;
    endcase
  endfunction

  // 8 == 1 mod 7: fold octal digits, then one conditional subtract
  function automatic logic [2:0] mod7(input logic [DNUM_W-1:0] v);
    logic [5:0] s;
    logic [3:0] f;
    s = 6'(v[2:0]) + 6'(v[5:3]) + 6'(v[8:6]) + 6'(v[11:9]) + 6'(v[14:12])
      + 6'(v[17:15]);
    f = 4'(s[5:3]) + 4'(s[2:0]);
    if (f >= 4'd7) begin
      f = f - 4'd7;
    end
    return f[2:0];
  endfunction

endpackage

// ----- hdl/cdcalc_pipe_ctrl.sv -----
// Valid tracking and stall control for the calculator pipeline.
// Depends on cdcalc_pkg.
`timescale 1ns / 1ps

module cdcalc_pipe_ctrl import cdcalc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      out_ready,
  output logic      in_ready,
  output pipe_ctl_t ctl
);

  logic [PIPE_DEPTH-1:0] vld_r, vld_nxt;
  logic                  adv;

  // whole pipe moves when the result slot is empty or being taken
  assign adv = !vld_r[PIPE_DEPTH-1] || out_ready;

  always_comb begin
    vld_nxt = vld_r;
    if (adv) begin
      vld_nxt = {vld_r[PIPE_DEPTH-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready    = adv;
  assign ctl.adv     = adv;
  assign ctl.out_vld = vld_r[PIPE_DEPTH-1];

endmodule

// ----- hdl/cdcalc_date_path.sv -----
// Datapath for one packed date: decimal split, validity, day of year and
// day number, four register stages. Depends on cdcalc_pkg.
`timescale 1ns / 1ps

module cdcalc_date_path import cdcalc_pkg::*; (
  input  logic              clk,
  input  logic              adv,
  input  logic [CODE_W-1:0] code,
  output date_info_t        info
);

  // stage 2: year digits
  logic [CODE_W-1:0] code2_r;
  logic [YEAR_W-1:0] year2_r, year2_nxt;
  logic [45:0]       prod_y;

  assign prod_y    = 46'(code[CODE_W-1:4]) * 46'(RECIP_10000);
  assign year2_nxt = prod_y[45:32];

  always_ff @(posedge clk) begin
    if (adv) begin
      code2_r <= code;
      year2_r <= year2_nxt;
    end
  end

  // stage 3: month-day remainder, leap flag, days before the year
  logic [YEAR_W-1:0] rem3_r, rem3_nxt, year3_r;
  logic              leap3_r, leap3_nxt, yok3_r, yok3_nxt;
  logic [DNUM_W-1:0] base3_r, base3_nxt;
  logic [27:0]       year_x;
  logic [CODE_W-1:0] rem_full;
  logic [23:0]       prod_q, prod_t;
  logic [7:0]        q100, tq100;
  logic [14:0]       q100_x;
  logic [YEAR_W-1:0] r100, t, ydiff;
  logic [11:0]       leapsum;

  assign year_x   = 28'(year2_r) * 28'(TEN_THOUSAND);
  assign rem_full = code2_r - year_x[CODE_W-1:0];
  assign rem3_nxt = rem_full[YEAR_W-1:0];

  assign prod_q = 24'(year2_r[YEAR_W-1:2]) * 24'(RECIP_100);
  assign q100   = prod_q[23:16];
  assign q100_x = 15'(q100) * 15'(HUNDRED);
  assign r100   = year2_r - q100_x[YEAR_W-1:0];
  assign leap3_nxt = ((year2_r[1:0] == 2'd0) && (r100 != '0))
                  || ((r100 == '0) && (q100[1:0] == 2'd0));

  // leap years in 1..year-1, then offset from the epoch
  assign t       = year2_r - 14'd1;
  assign prod_t  = 24'(t[YEAR_W-1:2]) * 24'(RECIP_100);
  assign tq100   = prod_t[23:16];
  assign leapsum = t[YEAR_W-1:2] - 12'(tq100) + 12'(tq100[7:2]);
  assign ydiff   = year2_r - YEAR_FIRST;
  assign base3_nxt = 18'(ydiff[8:0]) * 18'(DAYS_COMMON) + 18'(leapsum)
                   - 18'(LEAPS_BEFORE_EPOCH);
  assign yok3_nxt  = (year2_r >= YEAR_FIRST) && (year2_r <= YEAR_LAST);

  always_ff @(posedge clk) begin
    if (adv) begin
      rem3_r  <= rem3_nxt;
      year3_r <= year2_r;
      leap3_r <= leap3_nxt;
      yok3_r  <= yok3_nxt;
      base3_r <= base3_nxt;
    end
  end

  // stage 4: month and day digits
  logic [MD_W-1:0]   month4_r, month4_nxt, day4_r, day4_nxt;
  logic [YEAR_W-1:0] year4_r;
  logic              leap4_r, yok4_r;
  logic [DNUM_W-1:0] base4_r;
  logic [23:0]       prod_m;
  logic [7:0]        mq;
  logic [YEAR_W-1:0] m_x, day_full;

  assign prod_m     = 24'(rem3_r[YEAR_W-1:2]) * 24'(RECIP_100);
  assign mq         = prod_m[23:16];
  assign month4_nxt = mq[MD_W-1:0];
  assign m_x        = 14'(mq) * 14'(HUNDRED);
  assign day_full   = rem3_r - m_x;
  assign day4_nxt   = day_full[MD_W-1:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      month4_r <= month4_nxt;
      day4_r   <= day4_nxt;
      year4_r  <= year3_r;
      leap4_r  <= leap3_r;
      yok4_r   <= yok3_r;
      base4_r  <= base3_r;
    end
  end

  // stage 5: validity and derived fields, zeroed when invalid
  date_info_t        info5_r, info5_nxt;
  logic              mok, dok, ok;
  logic [3:0]        mi;
  logic [4:0]        mlen;
  logic [DOY_W-1:0]  doy, left;
  logic [DNUM_W-1:0] dnum;

  assign mok  = (month4_r >= 7'd1) && (month4_r <= 7'd12);
  assign mi   = month4_r[3:0] - 4'd1;
  assign mlen = month_len(mi, leap4_r);
  assign dok  = (day4_r >= 7'd1) && (day4_r <= 7'(mlen));
  assign ok   = yok4_r && mok && dok;
  assign doy  = cum_days(mi) + 9'(day4_r) + 9'(leap4_r && (month4_r > 7'd2));
  assign dnum = base4_r + 18'(doy) - 18'd1;
  assign left = (leap4_r ? DAYS_LEAP : DAYS_COMMON) - doy;

  always_comb begin
    info5_nxt.ok      = ok;
    info5_nxt.year    = year4_r;
    info5_nxt.month   = month4_r;
    info5_nxt.day     = day4_r;
    info5_nxt.leap    = leap4_r;
    info5_nxt.quarter = ok ? quarter_of(mi) : 3'd0;
    info5_nxt.doy     = ok ? doy : '0;
    info5_nxt.left    = ok ? left : '0;
    info5_nxt.dnum    = ok ? dnum : '0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      info5_r <= info5_nxt;
    end
  end

  assign info = info5_r;

endmodule

// ----- hdl/calendar_date_calculator_top.sv -----
// Channel   | Ports                               | Beat
// input     | in_valid/in_ready, in_date_code,    | two packed YYYYMMDD dates
//           | in_other_code                       |
// result    | out_valid/out_ready, out_*          | decoded first date + difference
//
// One beat accepted per cycle while the result slot is free or being taken; each
// beat passes through six register stages: input, year split, remainder and
// leap, month/day split, day number, result.
// Reset (rst_n, synchronous) clears the valid bits only.
// While a result waits on out_ready the whole pipeline holds, in_ready included.
// Depends on cdcalc_pkg, cdcalc_pipe_ctrl, cdcalc_date_path.
`timescale 1ns / 1ps

module calendar_date_calculator_top import cdcalc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CODE_W-1:0] in_date_code,
  input  logic [CODE_W-1:0] in_other_code,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_date_ok,
  output logic [YEAR_W-1:0] out_year_part,
  output logic [MD_W-1:0]   out_month_part,
  output logic [MD_W-1:0]   out_day_part,
  output logic [2:0]        out_quarter_no,
  output logic              out_is_leap,
  output logic [DOY_W-1:0]  out_day_of_year,
  output logic [DOY_W-1:0]  out_days_left,
  output logic [2:0]        out_weekday,
  output logic [DNUM_W-1:0] out_day_number,
  output logic              out_other_ok,
  output logic [DNUM_W-1:0] out_diff_days
);

  pipe_ctl_t ctl;

  cdcalc_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .in_ready  (in_ready),
    .ctl       (ctl)
  );

  // stage 1: input register
  logic [CODE_W-1:0] date_r, other_r;

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      date_r  <= in_date_code;
      other_r <= in_other_code;
    end
  end

  date_info_t info_a, info_b;

  cdcalc_date_path u_path_a (
    .clk  (clk),
    .adv  (ctl.adv),
    .code (date_r),
    .info (info_a)
  );

  cdcalc_date_path u_path_b (
    .clk  (clk),
    .adv  (ctl.adv),
    .code (other_r),
    .info (info_b)
  );

  // stage 6: result register
  date_info_t        res_r;
  logic              other_ok_r;
  logic [2:0]        weekday_r, weekday_nxt;
  logic [DNUM_W-1:0] diff_r, diff_nxt;

  // day numbers are already zero for an invalid date
  assign weekday_nxt = mod7(info_a.dnum);

  always_comb begin
    diff_nxt = '0;
    if (info_a.ok && info_b.ok) begin
      diff_nxt = (info_a.dnum >= info_b.dnum) ? (info_a.dnum - info_b.dnum)
                                              : (info_b.dnum - info_a.dnum);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      res_r      <= info_a;
      other_ok_r <= info_b.ok;
      weekday_r  <= weekday_nxt;
      diff_r     <= diff_nxt;
    end
  end

  assign out_valid       = ctl.out_vld;
  assign out_date_ok     = res_r.ok;
  assign out_year_part   = res_r.year;
  assign out_month_part  = res_r.month;
  assign out_day_part    = res_r.day;
  assign out_quarter_no  = res_r.quarter;
  assign out_is_leap     = res_r.leap;
  assign out_day_of_year = res_r.doy;
  assign out_days_left   = res_r.left;
  assign out_weekday     = weekday_r;
  assign out_day_number  = res_r.dnum;
  assign out_other_ok    = other_ok_r;
  assign out_diff_days   = diff_r;

endmodule

// ----- hdl/cdcalc_checker.sv -----
// Port-level checker for calendar_date_calculator_top, bound to the top level.
// Depends on cdcalc_pkg and calendar_date_calculator_top_macros.svh.
`timescale 1ns / 1ps
`include "calendar_date_calculator_top_macros.svh"

module cdcalc_checker import cdcalc_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_date_ok,
  input logic [YEAR_W-1:0] out_year_part,
  input logic [2:0]        out_quarter_no,
  input logic              out_is_leap,
  input logic [DOY_W-1:0]  out_day_of_year,
  input logic [DOY_W-1:0]  out_days_left,
  input logic [2:0]        out_weekday,
  input logic [DNUM_W-1:0] out_day_number,
  input logic [DNUM_W-1:0] out_diff_days
);

  // a stalled result beat keeps its payload
  `CDCALC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_day_number) && $stable(out_diff_days) && $stable(out_year_part), "result beat changed while stalled")

  // an empty result slot never blocks the input
  `CDCALC_ASSERT_NOW(a_in_free, !out_valid, in_ready, "input blocked with empty result slot")

  // invalid first date zeroes every derived field
  `CDCALC_ASSERT_NOW(a_invalid_zero, out_valid && !out_date_ok, (out_quarter_no == 3'd0) && (out_day_of_year == '0) && (out_days_left == '0) && (out_weekday == 3'd0) && (out_day_number == '0) && (out_diff_days == '0), "derived fields set for invalid date")

  // day of year and days left add up to the year length
  `CDCALC_ASSERT_NOW(a_year_len, out_valid && out_date_ok, ({1'b0, out_day_of_year} + {1'b0, out_days_left}) == (out_is_leap ? 10'd366 : 10'd365), "day of year and days left disagree")

endmodule

bind calendar_date_calculator_top cdcalc_checker u_cdcalc_checker (.*);
